/* design/tsa_pkg.sv */
// Package for the TCP segment-arrival engine: flag codes, event and state
// encodings, and the item, reply and sequence-variable structs.
// No dependencies.
package tsa_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] RECV_WINDOW_RESET = 16'hFFFF;

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	typedef enum logic [1:0] {
		ACT_SEGMENT      = 2'd0,
		ACT_ACTIVE_OPEN  = 2'd1,
		ACT_PASSIVE_OPEN = 2'd2,
		ACT_CLOSE        = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_CLOSED   = 3'd0,
		ST_LISTEN   = 3'd1,
		ST_SYN_SENT = 3'd2,
		ST_SYN_RCVD = 3'd3,
		ST_ESTAB    = 3'd4
	} conn_state_t;

	// One classified event as it sits in the queue.
	typedef struct packed {
		act_t        action;
		logic        matched;
		logic [31:0] seq;
		logic [31:0] ack;
		logic        fin;
		logic        syn;
		logic        rst;
		logic        ack_flag;
		logic [15:0] wnd;
		logic [31:0] iseq;
		logic [31:0] iseq_plus1;
		logic [31:0] seq_plus1;
		logic [31:0] seq_end;
		logic [31:0] seq_last;
		logic        len_zero;
	} tsa_item_t;

	typedef struct packed {
		logic        send;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [15:0] window;
	} tsa_reply_t;

	typedef struct packed {
		logic [31:0] snd_nxt;
		logic [31:0] snd_una;
		logic [15:0] snd_wnd;
		logic [31:0] wl1;
		logic [31:0] wl2;
		logic [31:0] iss;
		logic [31:0] irs;
		logic [31:0] rcv_nxt;
		logic [15:0] rcv_wnd;
	} tsa_vars_t;

	function automatic tsa_reply_t make_reply(logic [31:0] seq, logic [31:0] ack,
			logic [7:0] flags, logic [15:0] window);
		tsa_reply_t r;
		r.send   = 1'b1;
		r.seq    = seq;
		r.ack    = ack;
		r.flags  = flags;
		r.window = window;
		return r;
	endfunction

endpackage

/* design/tsa_front.sv */
// Front end of the TCP segment-arrival engine: decodes one event beat and
// precomputes the segment-length sums. Depends on tsa_pkg.
module tsa_front import tsa_pkg::*; (
	input  logic [1:0]  action,
	input  logic        for_this_connection,
	input  logic [31:0] seq_num,
	input  logic [31:0] ack_num,
	input  logic [7:0]  flags,
	input  logic [15:0] window,
	input  logic [15:0] data_len,
	input  logic [31:0] initial_seq,
	output tsa_item_t   item
);

	logic [16:0] seg_len;
	logic [31:0] seg_len_m1;

	// SYN and FIN each occupy one sequence number.
	assign seg_len = {1'b0, data_len} + {16'd0, (flags & FLAG_SYN) != 8'd0}
		+ {16'd0, (flags & FLAG_FIN) != 8'd0};
	assign seg_len_m1 = {15'd0, seg_len} - 32'd1;

	always_comb begin
		item.action     = act_t'(action);
		item.matched    = for_this_connection;
		item.seq        = seq_num;
		item.ack        = ack_num;
		item.fin        = (flags & FLAG_FIN) != 8'd0;
		item.syn        = (flags & FLAG_SYN) != 8'd0;
		item.rst        = (flags & FLAG_RST) != 8'd0;
		item.ack_flag   = (flags & FLAG_ACK) != 8'd0;
		item.wnd        = window;
		item.iseq       = initial_seq;
		item.iseq_plus1 = initial_seq + 32'd1;
		item.seq_plus1  = seq_num + 32'd1;
		item.seq_end    = seq_num + {15'd0, seg_len};
		item.seq_last   = seq_num + seg_len_m1;
		item.len_zero   = seg_len == 17'd0;
	end

endmodule

/* design/tsa_queue.sv */
// Short FIFO of classified events between the front and back ends.
// Depends on tsa_pkg.
module tsa_queue import tsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tsa_item_t push_item,
	input  logic      pop,
	output tsa_item_t head,
	output logic      full,
	output logic      empty
);

	tsa_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count over depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1)) else $error("push lost");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - QCNT_W'(1)) else $error("pop lost");

endmodule

/* design/tsa_back.sv */
// Back end of the TCP segment-arrival engine: connection state, sequence
// variables, reply generation and the output register. Depends on tsa_pkg.
module tsa_back import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  tsa_item_t   head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output tsa_reply_t  out_reply,
	output conn_state_t out_state
);

	logic [15:0] rwnd_cfg_q;
	conn_state_t state_q, state_d;
	tsa_vars_t   vars_q, vars_d;
	tsa_reply_t  rep_d;
	tsa_reply_t  out_rep_q;
	conn_state_t out_state_q;
	logic        out_valid_q;

	logic        seg_orphan;
	logic        ss_ack_bad;
	logic        ss_ok;
	logic [31:0] ss_una;
	logic        ss_estab;
	logic [31:0] rcv_top;
	logic        wnd_zero;
	logic        seq_in;
	logic        last_in;
	logic        sync_ok;

	assign pop = !empty && (!out_valid_q || out_ready);

	// Segment for another endpoint, or no connection at all.
	assign seg_orphan = !head.matched || state_q == ST_CLOSED;

	// SYN-SENT acknowledgment checks.
	assign ss_ack_bad = head.ack_flag && (head.ack <= vars_q.iss || head.ack > vars_q.snd_nxt);
	assign ss_ok = head.ack_flag && !ss_ack_bad && vars_q.snd_una <= head.ack
		&& head.ack <= vars_q.snd_nxt;
	assign ss_una = ss_ok ? head.ack : vars_q.snd_una;
	assign ss_estab = ss_una > vars_q.iss;

	// Receive-window acceptability for synchronized states.
	assign rcv_top  = vars_q.rcv_nxt + {16'd0, vars_q.rcv_wnd};
	assign wnd_zero = vars_q.rcv_wnd == 16'd0;
	assign seq_in   = vars_q.rcv_nxt <= head.seq && head.seq < rcv_top;
	assign last_in  = vars_q.rcv_nxt <= head.seq_last && head.seq_last < rcv_top;
	assign sync_ok  = head.len_zero ? (wnd_zero ? head.seq == vars_q.rcv_nxt : seq_in)
		: (!wnd_zero && (seq_in || last_in));

	// Next connection state.
	always_comb begin
		state_d = state_q;
		unique case (head.action)
			ACT_ACTIVE_OPEN: begin
				if (state_q == ST_CLOSED) state_d = ST_SYN_SENT;
			end
			ACT_PASSIVE_OPEN: begin
				if (state_q == ST_CLOSED) state_d = ST_LISTEN;
			end
			ACT_CLOSE: begin
				state_d = ST_CLOSED;
			end
			ACT_SEGMENT: begin
				if (!seg_orphan) begin
					unique case (state_q)
						ST_LISTEN: begin
							if (!head.rst && !head.ack_flag && head.syn) state_d = ST_SYN_RCVD;
						end
						ST_SYN_SENT: begin
							priority if (ss_ack_bad) begin
								state_d = ST_SYN_SENT;
							end else if (head.rst) begin
								if (ss_ok) state_d = ST_CLOSED;
							end else if (head.syn) begin
								state_d = ss_estab ? ST_ESTAB : ST_SYN_RCVD;
							end else begin
								state_d = state_q;
							end
						end
						default: state_d = state_q;
					endcase
				end
			end
			default: state_d = state_q;
		endcase
	end

	// Reply segment and sequence-variable updates.
	always_comb begin
		rep_d  = '0;
		vars_d = vars_q;
		unique case (head.action)
			ACT_ACTIVE_OPEN: begin
				if (state_q == ST_CLOSED) begin
					vars_d         = '0;
					vars_d.rcv_wnd = rwnd_cfg_q;
					vars_d.iss     = head.iseq;
					vars_d.snd_una = head.iseq;
					vars_d.snd_nxt = head.iseq_plus1;
					rep_d = make_reply(head.iseq, 32'd0, FLAG_SYN, rwnd_cfg_q);
				end
			end
			ACT_PASSIVE_OPEN: begin
				vars_d = vars_q;
			end
			ACT_CLOSE: begin
				if (state_q != ST_CLOSED) begin
					rep_d = make_reply(vars_q.snd_nxt, vars_q.rcv_nxt, FLAG_RST,
						vars_q.rcv_wnd);
					vars_d = '0;
				end
			end
			ACT_SEGMENT: begin
				if (seg_orphan) begin
					if (!head.rst) begin
						rep_d = head.ack_flag
							? make_reply(head.ack, 32'd0, FLAG_RST, 16'd0)
							: make_reply(32'd0, head.seq_end, FLAG_RST | FLAG_ACK, 16'd0);
					end
				end else begin
					unique case (state_q)
						ST_LISTEN: begin
							priority if (head.rst) begin
								rep_d = '0;
							end else if (head.ack_flag) begin
								rep_d = make_reply(head.ack, 32'd0, FLAG_RST, 16'd0);
							end else if (head.syn) begin
								vars_d.rcv_wnd = rwnd_cfg_q;
								vars_d.rcv_nxt = head.seq_plus1;
								vars_d.irs     = head.seq;
								vars_d.iss     = head.iseq;
								vars_d.snd_nxt = head.iseq_plus1;
								vars_d.snd_una = head.iseq;
								rep_d = make_reply(head.iseq, head.seq_plus1,
									FLAG_SYN | FLAG_ACK, rwnd_cfg_q);
							end else begin
								rep_d = '0;
							end
						end
						ST_SYN_SENT: begin
							priority if (ss_ack_bad) begin
								rep_d = make_reply(head.ack, 32'd0, FLAG_RST, 16'd0);
							end else if (head.rst) begin
								if (ss_ok) vars_d = '0;
							end else if (head.syn) begin
								vars_d.rcv_nxt = head.seq_plus1;
								vars_d.irs     = head.seq;
								vars_d.snd_una = ss_una;
								if (ss_estab) begin
									vars_d.snd_wnd = head.wnd;
									vars_d.wl1     = head.seq;
									vars_d.wl2     = head.ack;
									rep_d = make_reply(vars_q.snd_nxt, head.seq_plus1,
										FLAG_ACK, vars_q.rcv_wnd);
								end else begin
									rep_d = make_reply(vars_q.iss, head.seq_plus1,
										FLAG_SYN | FLAG_ACK, vars_q.rcv_wnd);
								end
							end else begin
								rep_d = '0;
							end
						end
						ST_SYN_RCVD, ST_ESTAB: begin
							if (!sync_ok && !head.rst) begin
								rep_d = make_reply(vars_q.snd_nxt, vars_q.rcv_nxt, FLAG_ACK,
									vars_q.rcv_wnd);
							end
						end
						default: rep_d = '0;
					endcase
				end
			end
			default: rep_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwnd_cfg_q  <= RECV_WINDOW_RESET;
			state_q     <= ST_CLOSED;
			vars_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) rwnd_cfg_q <= cfg_wdata;
			if (pop) begin
				state_q <= state_d;
				vars_q  <= vars_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_rep_q   <= rep_d;
			out_state_q <= state_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_reply = out_rep_q;
	assign out_state = out_state_q;

	a_quiet_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_rep_q.send |-> out_rep_q.seq == 32'd0 && out_rep_q.ack == 32'd0
		&& out_rep_q.flags == 8'd0 && out_rep_q.window == 16'd0)
		else $error("silent result carries nonzero fields");
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.action == ACT_CLOSE |=> state_q == ST_CLOSED && vars_q.snd_nxt == 32'd0)
		else $error("close left connection state");
	a_state_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && out_state_q == state_q)
		else $error("reported state differs from connection state");

endmodule

/* design/tcp_segment_arrival_fsm_unit.sv */
// Top level of the TCP segment-arrival engine: front decode, event queue and
// back end. Depends on tsa_pkg, tsa_front, tsa_queue and tsa_back.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ----------------------------------------------
//   event in  in_valid / in_ready    action, for_this_connection, seq_num, ack_num,
//                                    flags, window, data_len, initial_seq
//   reply out out_valid / out_ready  send_segment, out_seq, out_ack, out_flags,
//                                    out_window, conn_state
//   config    cfg_we (no wait)       cfg_wdata = receive window size
//
// Every event beat yields exactly one reply beat. An event is decoded in the
// cycle it is accepted and written into a two-entry queue; the back end takes
// one event per cycle and loads the result into the output register, so the
// sustained rate is one event per clock while out_ready does not stall it.
// in_ready falls only when the queue is full, which happens only while the
// output register is stalled by out_ready; the queue lets two more events in
// under such a stall. Reset leaves the connection closed, all sequence
// variables zero and the receive window size at 65535.
module tcp_segment_arrival_fsm_unit import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        for_this_connection,
	input  logic [31:0] seq_num,
	input  logic [31:0] ack_num,
	input  logic [7:0]  flags,
	input  logic [15:0] window,
	input  logic [15:0] data_len,
	input  logic [31:0] initial_seq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_segment,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [7:0]  out_flags,
	output logic [15:0] out_window,
	output logic [2:0]  conn_state,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	tsa_item_t   front_item;
	tsa_item_t   head;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	tsa_reply_t  reply;
	conn_state_t state_out;

	// The front end is pure decode; it only stalls when the queue is full.
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	tsa_front u_front (
		.action              (action),
		.for_this_connection (for_this_connection),
		.seq_num             (seq_num),
		.ack_num             (ack_num),
		.flags               (flags),
		.window              (window),
		.data_len            (data_len),
		.initial_seq         (initial_seq),
		.item                (front_item)
	);

	tsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// The back end pops whenever its output register is free or being drained.
	tsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_reply (reply),
		.out_state (state_out)
	);

	assign send_segment = reply.send;
	assign out_seq      = reply.seq;
	assign out_ack      = reply.ack;
	assign out_flags    = reply.flags;
	assign out_window   = reply.window;
	assign conn_state   = state_out;

endmodule

/* bench/tcp_segment_arrival_fsm_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the TCP segment-arrival engine: a connection-state predictor and
// reply scoreboard in tsa_bench_pkg, and the top module that drives events and window writes.
// Depends on tsa_pkg and tcp_segment_arrival_fsm_unit.
package tsa_bench_pkg;
	import tsa_pkg::*;

	typedef struct {
		act_t        action;
		logic        matched;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [15:0] wnd;
		logic [15:0] dlen;
		logic [31:0] iseq;
	} tcp_event_t;

	typedef struct {
		logic        send;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [15:0] window;
		logic [2:0]  state;
	} tcp_reply_t;

	class tcp_reply_board;
		conn_state_t link;
		logic [31:0] snd_nxt, snd_una, wl1, wl2, iss, irs, rcv_nxt;
		logic [15:0] snd_wnd, rcv_wnd, rcv_wnd_size;
		tcp_reply_t  expected_q[$];
		int          errors, events, replies, segments;
		bit [4:0]    states_seen;

		function void clear_link();
			link    = ST_CLOSED;
			snd_nxt = '0;
			snd_una = '0;
			snd_wnd = '0;
			wl1     = '0;
			wl2     = '0;
			iss     = '0;
			irs     = '0;
			rcv_nxt = '0;
			rcv_wnd = '0;
		endfunction

		function void restart();
			rcv_wnd_size = RECV_WINDOW_RESET;
			clear_link();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function tcp_reply_t reply_of(logic [31:0] seq, logic [31:0] ack, logic [7:0] flags,
				logic [15:0] window);
			tcp_reply_t r;
			r.send   = 1'b1;
			r.seq    = seq;
			r.ack    = ack;
			r.flags  = flags;
			r.window = window;
			r.state  = '0;
			return r;
		endfunction

		// Advances the connection by one accepted event and queues the reply it must produce.
		function void note_event(tcp_event_t ev);
			tcp_reply_t  r;
			logic [31:0] slen, top, last;
			bit          fin, syn, rst, ackf, ok, done;
			r    = '{default: '0};
			fin  = |(ev.flags & FLAG_FIN);
			syn  = |(ev.flags & FLAG_SYN);
			rst  = |(ev.flags & FLAG_RST);
			ackf = |(ev.flags & FLAG_ACK);
			slen = {16'd0, ev.dlen} + {31'd0, syn} + {31'd0, fin};
			ok   = 1'b0;
			done = 1'b0;
			case (ev.action)
				ACT_ACTIVE_OPEN: if (link == ST_CLOSED) begin
					clear_link();
					rcv_wnd = rcv_wnd_size;
					iss     = ev.iseq;
					r       = reply_of(iss, rcv_nxt, FLAG_SYN, rcv_wnd);
					snd_una = iss;
					snd_nxt = iss + 32'd1;
					link    = ST_SYN_SENT;
				end
				ACT_PASSIVE_OPEN: if (link == ST_CLOSED) begin
					link = ST_LISTEN;
				end
				ACT_CLOSE: if (link != ST_CLOSED) begin
					r = reply_of(snd_nxt, rcv_nxt, FLAG_RST, rcv_wnd);
					clear_link();
				end
				default: begin
					if (!ev.matched || link == ST_CLOSED) begin
						if (!rst && !ackf)
							r = reply_of(32'd0, ev.seq + slen, FLAG_RST | FLAG_ACK, 16'd0);
						else if (!rst)
							r = reply_of(ev.ack, 32'd0, FLAG_RST, 16'd0);
					end else if (link == ST_LISTEN) begin
						if (!rst && ackf) begin
							r = reply_of(ev.ack, 32'd0, FLAG_RST, 16'd0);
						end else if (!rst && syn) begin
							rcv_wnd = rcv_wnd_size;
							rcv_nxt = ev.seq + 32'd1;
							irs     = ev.seq;
							iss     = ev.iseq;
							r       = reply_of(iss, rcv_nxt, FLAG_SYN | FLAG_ACK, rcv_wnd);
							snd_nxt = iss + 32'd1;
							snd_una = iss;
							link    = ST_SYN_RCVD;
						end
					end else if (link == ST_SYN_SENT) begin
						if (ackf) begin
							if (ev.ack <= iss || ev.ack > snd_nxt) begin
								r    = reply_of(ev.ack, 32'd0, FLAG_RST, 16'd0);
								done = 1'b1;
							end else if (snd_una <= ev.ack && ev.ack <= snd_nxt) begin
								ok = 1'b1;
							end
						end
						if (!done && rst) begin
							// A reset only tears the attempt down when it acknowledges our SYN.
							if (ok)
								clear_link();
							done = 1'b1;
						end
						if (!done && syn) begin
							rcv_nxt = ev.seq + 32'd1;
							irs     = ev.seq;
							if (ok)
								snd_una = ev.ack;
							if (snd_una > iss) begin
								link    = ST_ESTAB;
								r       = reply_of(snd_nxt, rcv_nxt, FLAG_ACK, rcv_wnd);
								snd_wnd = ev.wnd;
								wl1     = ev.seq;
								wl2     = ev.ack;
							end else begin
								// Simultaneous open: our SYN is still unacknowledged.
								link = ST_SYN_RCVD;
								r    = reply_of(iss, rcv_nxt, FLAG_SYN | FLAG_ACK, rcv_wnd);
							end
						end
					end else begin
						// Synchronized states: plain unsigned window test, sums wrap at 32 bits.
						top = rcv_nxt + {16'd0, rcv_wnd};
						if (slen == 32'd0) begin
							if (rcv_wnd == 16'd0)
								ok = (ev.seq == rcv_nxt);
							else
								ok = (rcv_nxt <= ev.seq && ev.seq < top);
						end else if (rcv_wnd != 16'd0) begin
							last = ev.seq + slen - 32'd1;
							ok = (rcv_nxt <= ev.seq && ev.seq < top) ||
								(rcv_nxt <= last && last < top);
						end
						if (!ok && !rst)
							r = reply_of(snd_nxt, rcv_nxt, FLAG_ACK, rcv_wnd);
					end
				end
			endcase
			r.state = link;
			states_seen[link] = 1'b1;
			expected_q.push_back(r);
			events++;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(tcp_reply_t got);
			tcp_reply_t want;
			if (expected_q.size() == 0) begin
				$error("reply beat arrived with no event outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			replies++;
			if (got.send === 1'b1)
				segments++;
			compare_field("send_segment", 32'(want.send), 32'(got.send));
			compare_field("out_seq", want.seq, got.seq);
			compare_field("out_ack", want.ack, got.ack);
			compare_field("out_flags", 32'(want.flags), 32'(got.flags));
			compare_field("out_window", 32'(want.window), 32'(got.window));
			compare_field("conn_state", 32'(want.state), 32'(got.state));
		endfunction
	endclass

endpackage

// Top of the bench. One initial block runs reset, a directed walk through the connection
// states and eight randomized phases, each under its own receive-window setting. A second
// process sinks reply beats and checks them, and a watchdog ends the run if the handshakes
// stop moving.
module tcp_segment_arrival_fsm_unit_test;
	import tsa_pkg::*;
	import tsa_bench_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 96;
	localparam int PHASE_EVENTS   = 240;
	localparam int PHASES         = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_SEGMENT;
	logic        for_this_connection = 1'b0;
	logic [31:0] seq_num = '0;
	logic [31:0] ack_num = '0;
	logic [7:0]  flags = '0;
	logic [15:0] window = '0;
	logic [15:0] data_len = '0;
	logic [31:0] initial_seq = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        send_segment;
	logic [31:0] out_seq;
	logic [31:0] out_ack;
	logic [7:0]  out_flags;
	logic [15:0] out_window;
	logic [2:0]  conn_state;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	tcp_reply_board board = new;

	// Idling switches, flipped per phase by the main sequence.
	bit tx_idling = 1'b0;
	bit rx_idling = 1'b0;
	// A nonzero value asks the reply sink for one long hold-off of that many cycles.
	int rx_hold_req = 0;
	int window_writes = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	tcp_segment_arrival_fsm_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.action              (action),
		.for_this_connection (for_this_connection),
		.seq_num             (seq_num),
		.ack_num             (ack_num),
		.flags               (flags),
		.window              (window),
		.data_len            (data_len),
		.initial_seq         (initial_seq),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.send_segment        (send_segment),
		.out_seq             (out_seq),
		.out_ack             (out_ack),
		.out_flags           (out_flags),
		.out_window          (out_window),
		.conn_state          (conn_state),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata)
	);

	// Inputs change only through nonblocking assignments at the rising edge, and handshakes are
	// sampled in the active region right after the edge, so every check sees pre-edge values.

	// Offers one event beat and holds it until accepted. The predictor advances at the edge that
	// takes the beat; afterwards the sender may drop valid for a random burst of cycles.
	task automatic offer_event(input tcp_event_t ev);
		in_valid            <= 1'b1;
		action              <= ev.action;
		for_this_connection <= ev.matched;
		seq_num             <= ev.seq;
		ack_num             <= ev.ack;
		flags               <= ev.flags;
		window              <= ev.wnd;
		data_len            <= ev.dlen;
		initial_seq         <= ev.iseq;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_event(ev);
		if (tx_idling && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every reply beat owed has been taken. Every event yields
	// exactly one reply, so an empty scoreboard means the block is idle.
	task automatic hold_until_replied();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_window(input logic [15:0] size);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.rcv_wnd_size = size;
		window_writes++;
	endtask

	function automatic tcp_event_t segment_event(logic matched, logic [31:0] seq,
			logic [31:0] ack, logic [7:0] flg, logic [15:0] wnd, logic [15:0] dlen,
			logic [31:0] iseq);
		tcp_event_t ev;
		ev.action  = ACT_SEGMENT;
		ev.matched = matched;
		ev.seq     = seq;
		ev.ack     = ack;
		ev.flags   = flg;
		ev.wnd     = wnd;
		ev.dlen    = dlen;
		ev.iseq    = iseq;
		return ev;
	endfunction

	// Open and close events carry random segment fields, which the block must ignore.
	function automatic tcp_event_t control_event(act_t act, logic [31:0] iseq);
		tcp_event_t ev;
		ev = segment_event(1'($urandom_range(0, 1)), $urandom, $urandom,
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), iseq);
		ev.action = act;
		return ev;
	endfunction

	// Mostly well-formed traffic for the current predicted state, so that the handshake states
	// are reached often; the rest is unconstrained noise and stray opens and closes.
	function automatic tcp_event_t next_random_event();
		tcp_event_t ev;
		int         pick;
		pick = $urandom_range(0, 99);
		ev = segment_event(1'($urandom_range(0, 1)), $urandom, $urandom,
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 16)),
			$urandom);
		if (pick < 4) begin
			ev.action = ACT_CLOSE;
		end else if (pick < 8) begin
			ev.action = $urandom_range(0, 1) ? ACT_ACTIVE_OPEN : ACT_PASSIVE_OPEN;
		end else begin
			case (board.link)
				ST_CLOSED: begin
					if (pick < 50)
						ev.action = ACT_ACTIVE_OPEN;
					else if (pick < 80)
						ev.action = ACT_PASSIVE_OPEN;
				end
				ST_LISTEN: if (pick < 65) begin
					ev.matched = 1'b1;
					ev.flags = (8'($urandom_range(0, 255)) & ~(FLAG_RST | FLAG_ACK)) | FLAG_SYN;
				end
				ST_SYN_SENT: begin
					ev.matched = (pick < 95);
					if (pick < 55) begin
						ev.flags = FLAG_SYN | FLAG_ACK | (8'($urandom_range(0, 255)) & 8'hC8);
						ev.ack = ($urandom_range(0, 3) != 0) ? board.snd_nxt :
							board.iss + $urandom_range(0, 2);
					end else if (pick < 70) begin
						ev.flags = FLAG_SYN;
					end else if (pick < 80) begin
						ev.flags = FLAG_RST | FLAG_ACK;
						ev.ack = board.snd_nxt;
					end
				end
				default: if (pick < 85) begin
					// Aim at both edges of the receive window, including wrap-around.
					ev.matched = 1'b1;
					ev.dlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
					if ($urandom_range(0, 5) != 0)
						ev.flags = ev.flags & ~FLAG_RST;
					case ($urandom_range(0, 3))
						0: ev.seq = board.rcv_nxt + $urandom_range(0, 3);
						1: ev.seq = board.rcv_nxt - $urandom_range(1, 9);
						2: ev.seq = board.rcv_nxt + {16'd0, board.rcv_wnd}
							- $urandom_range(0, 3);
						default: ev.seq = board.rcv_nxt + {16'd0, board.rcv_wnd}
							+ $urandom_range(0, 3);
					endcase
				end
			endcase
		end
		return ev;
	endfunction

	// Directed walk: unmatched and closed replies, ignored opens, every listen branch, both ways
	// out of syn sent, the synchronized window test and closes from closed, syn rcvd and estab.
	task automatic run_directed();
		offer_event(segment_event(1'b1, 32'hFFFF_FFFF, 32'h0, FLAG_SYN | FLAG_FIN, 16'hFFFF,
			16'hFFFF, 32'h0));
		offer_event(segment_event(1'b1, 32'h0, 32'hFFFF_FFFF, FLAG_ACK, 16'h0, 16'h0,
			32'hFFFF_FFFF));
		offer_event(segment_event(1'b0, $urandom, $urandom, FLAG_RST | FLAG_ACK, 16'h0, 16'h0,
			32'h0));
		offer_event(control_event(ACT_CLOSE, $urandom));
		offer_event(control_event(ACT_PASSIVE_OPEN, $urandom));
		offer_event(control_event(ACT_PASSIVE_OPEN, $urandom));
		offer_event(control_event(ACT_ACTIVE_OPEN, 32'h1234));
		offer_event(segment_event(1'b0, 32'h10, 32'h0, 8'h00, 16'h0, 16'd3, 32'h0));
		offer_event(segment_event(1'b1, $urandom, $urandom, FLAG_RST, 16'h0, 16'h0, 32'h0));
		offer_event(segment_event(1'b1, $urandom, 32'hDEAD_BEEF, FLAG_ACK, 16'h0, 16'h0, 32'h0));
		offer_event(segment_event(1'b1, $urandom, $urandom, FLAG_FIN, 16'h0, 16'h0, 32'h0));
		// SYN in listen with a sequence number that wraps the receive pointer to zero.
		offer_event(segment_event(1'b1, 32'hFFFF_FFFF, 32'h0, FLAG_SYN | 8'h08, 16'h1000,
			16'h0, 32'hFFFF_FFFE));
		offer_event(segment_event(1'b1, board.rcv_nxt, 32'h0, FLAG_ACK, 16'h0, 16'h0, 32'h0));
		offer_event(segment_event(1'b1, board.rcv_nxt + 32'h0001_0000, 32'h0, FLAG_ACK, 16'h0,
			16'h0, 32'h0));
		offer_event(control_event(ACT_CLOSE, $urandom));
		offer_event(control_event(ACT_ACTIVE_OPEN, 32'd100));
		offer_event(segment_event(1'b1, 32'h0, 32'd100, FLAG_ACK, 16'h0, 16'h0, 32'h0));
		offer_event(segment_event(1'b1, 32'h0, 32'd101, FLAG_RST | FLAG_ACK, 16'h0, 16'h0,
			32'h0));
		// Active open at the top of the sequence space, then a simultaneous open.
		offer_event(control_event(ACT_ACTIVE_OPEN, 32'hFFFF_FFFF));
		offer_event(segment_event(1'b1, 32'h7, 32'h0, FLAG_SYN, 16'h0, 16'h0, 32'h0));
		offer_event(segment_event(1'b1, board.rcv_nxt + 32'hFFFE, 32'h0, FLAG_FIN | FLAG_ACK,
			16'h0, 16'h0, 32'h0));
		offer_event(control_event(ACT_CLOSE, $urandom));
		offer_event(control_event(ACT_ACTIVE_OPEN, 32'd5000));
		offer_event(segment_event(1'b1, 32'h0, 32'd5001, FLAG_SYN | FLAG_ACK, 16'hFFFF, 16'h0,
			32'h0));
		offer_event(segment_event(1'b1, board.rcv_nxt - 32'd1, $urandom, 8'hFF, 16'hFFFF,
			16'd1, 32'h0));
		offer_event(control_event(ACT_CLOSE, $urandom));
	endtask

	// Reply sink. It takes a beat whenever valid meets its own ready, then picks ready for the
	// next cycle: random stall bursts while idling is on, and one long hold-off on request.
	initial begin : reply_sink
		int         idle_left;
		tcp_reply_t got;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (out_ready && out_valid === 1'b1) begin
				got.send   = send_segment;
				got.seq    = out_seq;
				got.ack    = out_ack;
				got.flags  = out_flags;
				got.window = out_window;
				got.state  = conn_state;
				board.check_reply(got);
			end
			if (rx_hold_req > 0) begin
				idle_left = rx_hold_req;
				rx_hold_req = 0;
			end else if (idle_left == 0 && rx_idling && $urandom_range(0, 7) == 0) begin
				idle_left = $urandom_range(1, 15);
			end
			if (idle_left > 0) begin
				out_ready <= 1'b0;
				idle_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : main_sequence
		logic [15:0] size;
		board.restart();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idling = 1'b1;
		rx_idling = 1'b1;
		run_directed();

		for (int phase = 0; phase < PHASES; phase++) begin
			hold_until_replied();
			case (phase)
				0: size = 16'h0000;
				1: size = 16'hFFFF;
				2: size = 16'h0001;
				4: size = 16'h8000;
				5: size = 16'($urandom_range(0, 64));
				6: size = 16'h0000;
				default: size = 16'($urandom_range(0, 65535));
			endcase
			write_window(size);
			// Phase 1 runs with no idling at all; phase 2 keeps the sender busy against a long
			// receiver hold-off so the queue fills and in_ready drops; the last phase is clean.
			tx_idling = (phase != 1 && phase != 2 && phase != 6 && phase != PHASES - 1);
			rx_idling = (phase != 1 && phase != 5 && phase != PHASES - 1);
			if (phase == 2)
				rx_hold_req = HOLD_CYCLES;
			for (int i = 0; i < PHASE_EVENTS; i++) begin
				if (phase == 4 && i == PHASE_EVENTS / 2)
					hold_until_replied();
				offer_event(next_random_event());
			end
		end

		hold_until_replied();
		// A few more cycles so that any spurious reply beat is caught.
		repeat (8) @(posedge clk);

		$display("Run covered %0d event beats and %0d reply beats (%0d with a segment) under %0d",
			board.events, board.replies, board.segments, window_writes + 1);
		$display("receive-window settings; connection states reached (bit per state): %b",
			board.states_seen);
		if (board.errors == 0 && board.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
